// ===== hw/rtl/bdpt_pkg.sv =====
// bdpt_pkg: shared types, codes and constants of the bus device presence table
// used by every module of the block, no dependencies
`default_nettype none

package bdpt_pkg;

  localparam int unsigned MaxControllers = 32;
  localparam int unsigned MaxVirtual     = 16;

  localparam int unsigned KeyW  = 29;
  localparam int unsigned VKeyW = 14;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    OP_MSG   = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MCU_FIRST  = 3'd0,
    CFG_MCU_SECOND = 3'd1,
    CFG_TIMEOUT    = 3'd2,
    CFG_IGNITER    = 3'd3,
    CFG_DETECTOR   = 3'd4,
    CFG_BUTTON     = 3'd5,
    CFG_LIMIT      = 3'd6,
    CFG_SPARE      = 3'd7
  } cfg_idx_e;

  localparam logic [7:0]  RstMcuFirst  = 8'd13;
  localparam logic [7:0]  RstMcuSecond = 8'd14;
  localparam logic [15:0] RstTimeout   = 16'd5000;
  localparam logic [7:0]  RstIgniter   = 8'd1;
  localparam logic [7:0]  RstDetector  = 8'd2;
  localparam logic [7:0]  RstButton    = 8'd3;
  localparam logic [7:0]  RstLimit     = 8'd4;

  localparam logic [1:0] MACT_NONE    = 2'd0;
  localparam logic [1:0] MACT_REFRESH = 2'd1;
  localparam logic [1:0] MACT_APPEND  = 2'd2;
  localparam logic [1:0] MACT_FULL    = 2'd3;

  localparam logic [2:0] VACT_NONE      = 3'd0;
  localparam logic [2:0] VACT_UPDATE    = 3'd1;
  localparam logic [2:0] VACT_APPEND    = 3'd2;
  localparam logic [2:0] VACT_NO_PARENT = 3'd3;
  localparam logic [2:0] VACT_FULL      = 3'd4;

  typedef struct packed {
    op_e         op;
    logic [31:0] now;
    logic        dir;
    logic        is_mcu;
    logic        is_vdev;
    logic [7:0]  dtype;
    logic [6:0]  zone;
    logic [7:0]  hadr;
    logic [5:0]  ladr;
    logic [7:0]  cmd;
    logic [7:0]  mask;
  } item_t;

  typedef struct packed {
    logic [1:0] mcu_action;
    logic [4:0] mcu_slot;
    logic       mask_written;
    logic [2:0] vdev_action;
    logic [3:0] vdev_slot;
    logic       changed_flag;
    logic [5:0] aged_count;
    logic [5:0] entry_count;
  } res_t;

  typedef struct packed {
    logic [VKeyW-1:0] key;
    logic             chg;
    logic             on;
    logic [7:0]       cmd;
  } vent_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bus_device_presence_table_unit.sv =====
// bus_device_presence_table_unit: top level of the bus device presence table
// depends on bdpt_pkg, bdpt_front, bdpt_fifo, bdpt_back
//
//   channel  valid       stall       payload
//   in       in_valid_i  in_stall_o  op_i .. payload_rest_i
//   out      out_valid_o out_stall_i mcu_action_o .. entry_count_o
//   cfg      cfg_we_i    -           cfg_idx_i, cfg_wdata_i
//
// a message walks the controller entries one by one and, for a virtual device,
// then the virtual entries of the parent; a tick walks every used entry
// the search loop over the controller memory (one read port) sets the rate
// clear and reset zero the control state only; memories need no sweep
// a two-entry queue and the result register let input and output stall apart
`default_nettype none

module bus_device_presence_table_unit #(
  parameter int unsigned MAX_CONTROLLERS = bdpt_pkg::MaxControllers,
  parameter int unsigned MAX_VIRTUAL     = bdpt_pkg::MaxVirtual
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bdpt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bdpt_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [31:0]                   now_ms_i,
  input  wire logic                          dir_bit_i,
  input  wire logic [7:0]                    device_type_i,
  input  wire logic [6:0]                    zone_id_i,
  input  wire logic [7:0]                    high_address_i,
  input  wire logic [5:0]                    low_address_i,
  input  wire logic [7:0]                    cmd_byte_i,
  input  wire logic [55:0]                   payload_rest_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         mcu_action_o,
  output logic [4:0]                         mcu_slot_o,
  output logic                               mask_written_o,
  output logic [2:0]                         vdev_action_o,
  output logic [3:0]                         vdev_slot_o,
  output logic                               changed_flag_o,
  output logic [5:0]                         aged_count_o,
  output logic [5:0]                         entry_count_o
);

  bdpt_pkg::item_t push_item, pop_item;
  bdpt_pkg::res_t  res;
  logic            q_push, q_full, q_pop, q_valid;
  logic [15:0]     timeout;

  bdpt_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .op_i,
    .now_ms_i,
    .dir_bit_i,
    .device_type_i,
    .zone_id_i,
    .high_address_i,
    .low_address_i,
    .cmd_byte_i,
    .payload_rest_i,
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (push_item),
    .timeout_o (timeout)
  );

  bdpt_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  bdpt_back #(
    .MAX_CONTROLLERS (MAX_CONTROLLERS),
    .MAX_VIRTUAL     (MAX_VIRTUAL)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .timeout_i   (timeout),
    .out_valid_o,
    .out_stall_i,
    .res_o       (res)
  );

  assign mcu_action_o   = res.mcu_action;
  assign mcu_slot_o     = res.mcu_slot;
  assign mask_written_o = res.mask_written;
  assign vdev_action_o  = res.vdev_action;
  assign vdev_slot_o    = res.vdev_slot;
  assign changed_flag_o = res.changed_flag;
  assign aged_count_o   = res.aged_count;
  assign entry_count_o  = res.entry_count;

endmodule

`default_nettype wire

// ===== hw/rtl/bdpt_fifo.sv =====
// bdpt_fifo: two-entry queue of classified items between front and back
// depends on bdpt_pkg
`default_nettype none

module bdpt_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  bdpt_pkg::item_t     item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output bdpt_pkg::item_t     item_o
);

  bdpt_pkg::item_t mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rp_q];

endmodule

`default_nettype wire

// ===== hw/rtl/bdpt_front.sv =====
// bdpt_front: configuration registers, input acceptance and message classification
// depends on bdpt_pkg
`default_nettype none

module bdpt_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bdpt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bdpt_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [31:0]                   now_ms_i,
  input  wire logic                          dir_bit_i,
  input  wire logic [7:0]                    device_type_i,
  input  wire logic [6:0]                    zone_id_i,
  input  wire logic [7:0]                    high_address_i,
  input  wire logic [5:0]                    low_address_i,
  input  wire logic [7:0]                    cmd_byte_i,
  input  wire logic [55:0]                   payload_rest_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output bdpt_pkg::item_t                    q_item_o,
  output logic [15:0]                        timeout_o
);

  logic [7:0]  mcu_a_q, mcu_b_q, ign_q, det_q, btn_q, lim_q;
  logic [15:0] tmo_q;
  logic        is_mcu, is_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcu_a_q <= bdpt_pkg::RstMcuFirst;
      mcu_b_q <= bdpt_pkg::RstMcuSecond;
      tmo_q   <= bdpt_pkg::RstTimeout;
      ign_q   <= bdpt_pkg::RstIgniter;
      det_q   <= bdpt_pkg::RstDetector;
      btn_q   <= bdpt_pkg::RstButton;
      lim_q   <= bdpt_pkg::RstLimit;
    end else if (cfg_we_i) begin
      unique case (bdpt_pkg::cfg_idx_e'(cfg_idx_i))
        bdpt_pkg::CFG_MCU_FIRST:  mcu_a_q <= cfg_wdata_i[7:0];
        bdpt_pkg::CFG_MCU_SECOND: mcu_b_q <= cfg_wdata_i[7:0];
        bdpt_pkg::CFG_TIMEOUT:    tmo_q   <= cfg_wdata_i;
        bdpt_pkg::CFG_IGNITER:    ign_q   <= cfg_wdata_i[7:0];
        bdpt_pkg::CFG_DETECTOR:   det_q   <= cfg_wdata_i[7:0];
        bdpt_pkg::CFG_BUTTON:     btn_q   <= cfg_wdata_i[7:0];
        bdpt_pkg::CFG_LIMIT:      lim_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    is_mcu = (device_type_i == mcu_a_q) || (device_type_i == mcu_b_q);
    is_acc = (device_type_i == ign_q) || (device_type_i == det_q) ||
             (device_type_i == btn_q) || (device_type_i == lim_q);
    q_item_o.op      = bdpt_pkg::op_e'(op_i);
    q_item_o.now     = now_ms_i;
    q_item_o.dir     = dir_bit_i;
    q_item_o.is_mcu  = is_mcu;
    q_item_o.is_vdev = dir_bit_i && !is_mcu && is_acc;
    q_item_o.dtype   = device_type_i;
    q_item_o.zone    = zone_id_i;
    q_item_o.hadr    = high_address_i;
    q_item_o.ladr    = low_address_i;
    q_item_o.cmd     = cmd_byte_i;
    // bus mask is payload byte five
    q_item_o.mask    = payload_rest_i[39:32];
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign timeout_o  = tmo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bdpt_back.sv =====
// bdpt_back: sequencer over controller and virtual device memories, result register
// depends on bdpt_pkg
`default_nettype none

module bdpt_back #(
  parameter int unsigned MAX_CONTROLLERS = bdpt_pkg::MaxControllers,
  parameter int unsigned MAX_VIRTUAL     = bdpt_pkg::MaxVirtual
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  bdpt_pkg::item_t  q_item_i,
  output logic             q_pop_o,
  input  wire logic [15:0] timeout_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output bdpt_pkg::res_t   res_o
);

  localparam int unsigned CW   = (MAX_CONTROLLERS > 1) ? $clog2(MAX_CONTROLLERS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_CONTROLLERS + 1);
  localparam int unsigned VW   = (MAX_VIRTUAL > 1) ? $clog2(MAX_VIRTUAL) : 1;
  localparam int unsigned VCW  = $clog2(MAX_VIRTUAL + 1);
  localparam int unsigned VT   = MAX_CONTROLLERS * MAX_VIRTUAL;
  localparam int unsigned VAW  = (VT > 1) ? $clog2(VT) : 1;
  localparam int unsigned KW   = bdpt_pkg::KeyW;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MC_RD  = 12'b0000_0000_0010,
    S_MC_CMP = 12'b0000_0000_0100,
    S_MC_FIN = 12'b0000_0000_1000,
    S_PA_RD  = 12'b0000_0001_0000,
    S_PA_CMP = 12'b0000_0010_0000,
    S_VD_RD  = 12'b0000_0100_0000,
    S_VD_CMP = 12'b0000_1000_0000,
    S_VD_FIN = 12'b0001_0000_0000,
    S_TK_RD  = 12'b0010_0000_0000,
    S_TK_CMP = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  bdpt_pkg::item_t cur_q, cur_d;
  bdpt_pkg::res_t  res_q, res_d, out_q, out_d;
  logic            out_valid_q, out_valid_d, out_load;

  logic [CNTW-1:0]            idx_q, idx_d, used_q, used_d;
  logic [MAX_CONTROLLERS-1:0] online_q, online_d;
  logic                       hit_q, hit_d;
  logic [VCW-1:0]             vidx_q, vidx_d, vused_q, vused_d;
  logic [CNTW-1:0]            aged_q, aged_d;

  // controller memory: {key, last seen}
  logic [KW+31:0] ctl_mem [MAX_CONTROLLERS];
  logic [KW+31:0] ctl_rd_q, ctl_wd;
  logic           ctl_we;
  logic [CW-1:0]  ctl_wa;

  logic [VCW-1:0] vu_mem [MAX_CONTROLLERS];
  logic [VCW-1:0] vu_rd_q, vu_wd;
  logic           vu_we;
  logic [CW-1:0]  vu_wa;

  logic [7:0]     mask_mem [MAX_CONTROLLERS];
  logic [7:0]     mask_wd;
  logic           mask_we;
  logic [CW-1:0]  mask_wa;

  bdpt_pkg::vent_t vd_mem [VT];
  bdpt_pkg::vent_t vd_rd_q, vd_wd;
  logic            vd_we;
  logic [VAW-1:0]  vd_wa, vd_ra;

  logic [KW-1:0]              cur_key;
  logic [bdpt_pkg::VKeyW-1:0] cur_vkey;
  logic [CW-1:0]              ci, ui;
  logic [31:0]                age;
  logic                       chg;

  always_ff @(posedge clk_i) begin
    if (ctl_we) begin
      ctl_mem[ctl_wa] <= ctl_wd;
    end
    ctl_rd_q <= ctl_mem[ci];
  end

  always_ff @(posedge clk_i) begin
    if (vu_we) begin
      vu_mem[vu_wa] <= vu_wd;
    end
    vu_rd_q <= vu_mem[ci];
  end

  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[mask_wa] <= mask_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vd_we) begin
      vd_mem[vd_wa] <= vd_wd;
    end
    vd_rd_q <= vd_mem[vd_ra];
  end

  always_comb begin
    cur_key  = {cur_q.dtype, cur_q.zone, cur_q.hadr, cur_q.ladr};
    cur_vkey = {cur_q.dtype, cur_q.ladr};
    ci       = idx_q[CW-1:0];
    ui       = used_q[CW-1:0];
    age      = cur_q.now - ctl_rd_q[31:0];
    vd_ra    = VAW'(int'(ci) * MAX_VIRTUAL + int'(vidx_q[VW-1:0]));
    chg      = vd_rd_q.chg || (vd_rd_q.on && (vd_rd_q.cmd != cur_q.cmd));

    state_d  = state_q;
    cur_d    = cur_q;
    res_d    = res_q;
    idx_d    = idx_q;
    used_d   = used_q;
    online_d = online_q;
    hit_d    = hit_q;
    vidx_d   = vidx_q;
    vused_d  = vused_q;
    aged_d   = aged_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;

    ctl_we  = 1'b0;
    ctl_wa  = ci;
    ctl_wd  = {cur_key, cur_q.now};
    vu_we   = 1'b0;
    vu_wa   = ci;
    vu_wd   = '0;
    mask_we = 1'b0;
    mask_wa = ci;
    mask_wd = '0;
    vd_we   = 1'b0;
    vd_wa   = vd_ra;
    vd_wd   = '{key: cur_vkey, chg: 1'b0, on: 1'b1, cmd: cur_q.cmd};

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          idx_d   = '0;
          hit_d   = 1'b0;
          aged_d  = '0;
          res_d   = '0;
          priority if (q_item_i.op == bdpt_pkg::OP_CLEAR) begin
            used_d   = '0;
            online_d = '0;
            state_d  = S_DONE;
          end else if (q_item_i.op == bdpt_pkg::OP_TICK) begin
            state_d = S_TK_RD;
          end else if (q_item_i.op == bdpt_pkg::OP_MSG && q_item_i.is_mcu) begin
            state_d = S_MC_RD;
          end else if (q_item_i.op == bdpt_pkg::OP_MSG && q_item_i.is_vdev) begin
            state_d = S_PA_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MC_RD: begin
        state_d = (idx_q >= used_q) ? S_MC_FIN : S_MC_CMP;
      end
      S_MC_CMP: begin
        if (ctl_rd_q[KW+31:32] == cur_key) begin
          hit_d   = 1'b1;
          state_d = S_MC_FIN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_MC_RD;
        end
      end
      S_MC_FIN: begin
        state_d = S_DONE;
        mask_wd = cur_q.mask;
        if (hit_q) begin
          if (cur_q.dir) begin
            ctl_we           = 1'b1;
            online_d[ci]     = 1'b1;
            res_d.mcu_action = bdpt_pkg::MACT_REFRESH;
            res_d.mcu_slot   = 5'(ci);
          end
          if ((cur_q.dir || online_q[ci]) && cur_q.cmd == 8'd0) begin
            mask_we            = 1'b1;
            res_d.mask_written = 1'b1;
            res_d.mcu_slot     = 5'(ci);
          end
        end else if (cur_q.dir) begin
          if (used_q < CNTW'(MAX_CONTROLLERS)) begin
            ctl_we             = 1'b1;
            ctl_wa             = ui;
            vu_we              = 1'b1;
            vu_wa              = ui;
            mask_we            = 1'b1;
            mask_wa            = ui;
            mask_wd            = (cur_q.cmd == 8'd0) ? cur_q.mask : 8'd0;
            online_d[ui]       = 1'b1;
            used_d             = used_q + 1'b1;
            res_d.mcu_action   = bdpt_pkg::MACT_APPEND;
            res_d.mcu_slot     = 5'(ui);
            res_d.mask_written = (cur_q.cmd == 8'd0);
          end else begin
            res_d.mcu_action = bdpt_pkg::MACT_FULL;
          end
        end
      end
      S_PA_RD: begin
        if (idx_q >= used_q) begin
          res_d.vdev_action = bdpt_pkg::VACT_NO_PARENT;
          state_d           = S_DONE;
        end else begin
          state_d = S_PA_CMP;
        end
      end
      S_PA_CMP: begin
        if (online_q[ci] && ctl_rd_q[KW+31-8:32+6] == {cur_q.zone, cur_q.hadr}) begin
          vused_d = vu_rd_q;
          vidx_d  = '0;
          state_d = S_VD_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_PA_RD;
        end
      end
      S_VD_RD: begin
        if (vidx_q >= vused_q) begin
          if (vused_q >= VCW'(MAX_VIRTUAL)) begin
            res_d.vdev_action = bdpt_pkg::VACT_FULL;
            state_d           = S_DONE;
          end else begin
            hit_d   = 1'b0;
            state_d = S_VD_FIN;
          end
        end else begin
          state_d = S_VD_CMP;
        end
      end
      S_VD_CMP: begin
        if (vd_rd_q.key == cur_vkey) begin
          hit_d   = 1'b1;
          state_d = S_VD_FIN;
        end else begin
          vidx_d  = vidx_q + 1'b1;
          state_d = S_VD_RD;
        end
      end
      S_VD_FIN: begin
        vd_we           = 1'b1;
        res_d.vdev_slot = 4'(vidx_q[VW-1:0]);
        if (hit_q) begin
          vd_wd.chg          = chg;
          res_d.vdev_action  = bdpt_pkg::VACT_UPDATE;
          res_d.changed_flag = chg;
        end else begin
          vu_we             = 1'b1;
          vu_wd             = vused_q + 1'b1;
          res_d.vdev_action = bdpt_pkg::VACT_APPEND;
        end
        state_d = S_DONE;
      end
      S_TK_RD: begin
        if (idx_q >= used_q) begin
          res_d.aged_count = 6'(aged_q);
          state_d          = S_DONE;
        end else begin
          state_d = S_TK_CMP;
        end
      end
      S_TK_CMP: begin
        if (online_q[ci] && age > {16'd0, timeout_i}) begin
          online_d[ci] = 1'b0;
          vu_we        = 1'b1;
          mask_we      = 1'b1;
          aged_d       = aged_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_TK_RD;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d       = out_load || (out_valid_q && out_stall_i);
    out_d             = res_q;
    out_d.entry_count = 6'(used_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      online_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      online_q    <= online_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    res_q   <= res_d;
    idx_q   <= idx_d;
    hit_q   <= hit_d;
    vidx_q  <= vidx_d;
    vused_q <= vused_d;
    aged_q  <= aged_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ===== verif/tb_bus_device_presence_table_unit.sv =====
// testbench for bus_device_presence_table_unit: random and directed bus traffic,
// results checked against an in-bench model of the presence tables
// depends on bdpt_pkg and the block's rtl only
`timescale 1ns / 100ps

module tb_bus_device_presence_table_unit;

  typedef struct packed {
    bdpt_pkg::op_e op;
    logic [31:0]   now;
    logic          dir;
    logic [7:0]    dtype;
    logic [6:0]    zone;
    logic [7:0]    hadr;
    logic [5:0]    ladr;
    logic [7:0]    cmd;
    logic [55:0]   rest;
  } bus_item_t;

  class presence_scoreboard;
    logic [7:0]  mcu_a, mcu_b, ign, det, btn, lim;
    logic [15:0] tmo;
    logic [28:0] ckey[bdpt_pkg::MaxControllers];
    logic [31:0] cseen[bdpt_pkg::MaxControllers];
    bit          con[bdpt_pkg::MaxControllers];
    logic [7:0]  cmask[bdpt_pkg::MaxControllers];
    int          cvused[bdpt_pkg::MaxControllers];
    int          ccount;
    logic [13:0] vkey[bdpt_pkg::MaxControllers][bdpt_pkg::MaxVirtual];
    bit          von[bdpt_pkg::MaxControllers][bdpt_pkg::MaxVirtual];
    bit          vchg[bdpt_pkg::MaxControllers][bdpt_pkg::MaxVirtual];
    logic [7:0]  vcmd[bdpt_pkg::MaxControllers][bdpt_pkg::MaxVirtual];
    bdpt_pkg::res_t pending_q[$];
    int          errors;
    int          checked;
    int          full_seen;
    int          parent_full_seen;
    int          aged_seen;

    function new();
      mcu_a = bdpt_pkg::RstMcuFirst; mcu_b = bdpt_pkg::RstMcuSecond;
      tmo = bdpt_pkg::RstTimeout;
      ign = bdpt_pkg::RstIgniter; det = bdpt_pkg::RstDetector;
      btn = bdpt_pkg::RstButton; lim = bdpt_pkg::RstLimit;
      errors = 0; checked = 0; full_seen = 0; parent_full_seen = 0; aged_seen = 0;
      wipe_all();
    endfunction

    function void wipe_vdevs(int c);
      for (int v = 0; v < bdpt_pkg::MaxVirtual; v++) begin
        vkey[c][v] = '0; von[c][v] = 0; vchg[c][v] = 0; vcmd[c][v] = '0;
      end
      cvused[c] = 0;
    endfunction

    function void wipe_all();
      for (int c = 0; c < bdpt_pkg::MaxControllers; c++) begin
        ckey[c] = '0; cseen[c] = '0; con[c] = 0; cmask[c] = '0;
        wipe_vdevs(c);
      end
      ccount = 0;
    endfunction

    function void set_reg(bdpt_pkg::cfg_idx_e idx, logic [15:0] val);
      case (idx)
        bdpt_pkg::CFG_MCU_FIRST:  mcu_a = val[7:0];
        bdpt_pkg::CFG_MCU_SECOND: mcu_b = val[7:0];
        bdpt_pkg::CFG_TIMEOUT:    tmo = val;
        bdpt_pkg::CFG_IGNITER:    ign = val[7:0];
        bdpt_pkg::CFG_DETECTOR:   det = val[7:0];
        bdpt_pkg::CFG_BUTTON:     btn = val[7:0];
        bdpt_pkg::CFG_LIMIT:      lim = val[7:0];
        default: ;
      endcase
    endfunction

    function void note_input(bus_item_t it);
      bdpt_pkg::res_t r;
      logic [28:0] key;
      logic [13:0] vk;
      logic [31:0] diff;
      bit          is_mcu, hit;
      int          parent, found, v;
      r = '0;
      if (it.op == bdpt_pkg::OP_MSG) begin
        is_mcu = (it.dtype == mcu_a) || (it.dtype == mcu_b);
        key = {it.dtype, it.zone, it.hadr, it.ladr};
        if (it.dir && is_mcu) begin
          hit = 0;
          for (int c = 0; c < ccount; c++) begin
            if (ckey[c] == key) begin
              cseen[c] = it.now; con[c] = 1;
              r.mcu_action = bdpt_pkg::MACT_REFRESH; r.mcu_slot = 5'(c); hit = 1;
              break;
            end
          end
          if (!hit) begin
            if (ccount < bdpt_pkg::MaxControllers) begin
              ckey[ccount] = key; cseen[ccount] = it.now; con[ccount] = 1;
              cmask[ccount] = '0; cvused[ccount] = 0;
              r.mcu_action = bdpt_pkg::MACT_APPEND; r.mcu_slot = 5'(ccount);
              ccount++;
            end else begin
              r.mcu_action = bdpt_pkg::MACT_FULL;
              full_seen++;
            end
          end
        end
        if (is_mcu && it.cmd == 8'd0) begin
          for (int c = 0; c < ccount; c++) begin
            if (con[c] && ckey[c] == key) begin
              cmask[c] = it.rest[39:32];
              r.mask_written = 1'b1; r.mcu_slot = 5'(c);
              break;
            end
          end
        end
        if (it.dir && !is_mcu && (it.dtype == ign || it.dtype == det ||
            it.dtype == btn || it.dtype == lim)) begin
          parent = -1;
          for (int c = 0; c < ccount; c++) begin
            if (con[c] && ckey[c][20:6] == {it.zone, it.hadr}) begin
              parent = c;
              break;
            end
          end
          if (parent < 0) begin
            r.vdev_action = bdpt_pkg::VACT_NO_PARENT;
          end else begin
            vk = {it.dtype, it.ladr};
            found = -1;
            for (int i = 0; i < cvused[parent]; i++) begin
              if (vkey[parent][i] == vk) begin
                found = i;
                break;
              end
            end
            if (found < 0 && cvused[parent] >= bdpt_pkg::MaxVirtual) begin
              r.vdev_action = bdpt_pkg::VACT_FULL;
              parent_full_seen++;
            end else begin
              if (found < 0) begin
                v = cvused[parent];
                cvused[parent]++;
                vkey[parent][v] = vk; von[parent][v] = 0;
                vchg[parent][v] = 0; vcmd[parent][v] = '0;
                r.vdev_action = bdpt_pkg::VACT_APPEND;
              end else begin
                v = found;
                r.vdev_action = bdpt_pkg::VACT_UPDATE;
              end
              if (von[parent][v] && vcmd[parent][v] != it.cmd) vchg[parent][v] = 1;
              von[parent][v] = 1;
              vcmd[parent][v] = it.cmd;
              r.vdev_slot = 4'(v);
              r.changed_flag = vchg[parent][v];
            end
          end
        end
      end else if (it.op == bdpt_pkg::OP_TICK) begin
        for (int c = 0; c < ccount; c++) begin
          diff = it.now - cseen[c];
          if (con[c] && diff > {16'd0, tmo}) begin
            con[c] = 0; cmask[c] = '0;
            wipe_vdevs(c);
            r.aged_count++;
            aged_seen++;
          end
        end
      end else if (it.op == bdpt_pkg::OP_CLEAR) begin
        wipe_all();
      end
      r.entry_count = 6'(ccount);
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(bdpt_pkg::res_t got);
      bdpt_pkg::res_t want;
      if (pending_q.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      want = pending_q.pop_front();
      checked++;
      cmp("mcu_action", int'(got.mcu_action), int'(want.mcu_action));
      cmp("mcu_slot", int'(got.mcu_slot), int'(want.mcu_slot));
      cmp("mask_written", int'(got.mask_written), int'(want.mask_written));
      cmp("vdev_action", int'(got.vdev_action), int'(want.vdev_action));
      cmp("vdev_slot", int'(got.vdev_slot), int'(want.vdev_slot));
      cmp("changed_flag", int'(got.changed_flag), int'(want.changed_flag));
      cmp("aged_count", int'(got.aged_count), int'(want.aged_count));
      cmp("entry_count", int'(got.entry_count), int'(want.entry_count));
    endtask
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [bdpt_pkg::CfgIdxW-1:0] cfg_idx;
  logic [bdpt_pkg::CfgDataW-1:0] cfg_wdata;
  logic in_valid, in_stall, out_valid, out_stall;
  bus_item_t drv;
  bdpt_pkg::res_t got;

  presence_scoreboard sb;
  int hold_cycles_req;
  int sent;
  int settings_used;
  logic [31:0] cur_now;
  logic [7:0]  pool_type[40];
  logic [6:0]  pool_zone[40];
  logic [7:0]  pool_hadr[40];
  logic [5:0]  pool_ladr[40];

  bus_device_presence_table_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(drv.op), .now_ms_i(drv.now), .dir_bit_i(drv.dir),
    .device_type_i(drv.dtype), .zone_id_i(drv.zone), .high_address_i(drv.hadr),
    .low_address_i(drv.ladr), .cmd_byte_i(drv.cmd), .payload_rest_i(drv.rest),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .mcu_action_o(got.mcu_action), .mcu_slot_o(got.mcu_slot),
    .mask_written_o(got.mask_written), .vdev_action_o(got.vdev_action),
    .vdev_slot_o(got.vdev_slot), .changed_flag_o(got.changed_flag),
    .aged_count_o(got.aged_count), .entry_count_o(got.entry_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: long hold-off on request, otherwise a changing stall pattern
  initial begin
    int hold, cyc, mode;
    hold = 0; cyc = 0; mode = 0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles_req > 0) begin
        hold = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      cyc++;
      if (hold > 0) begin
        out_stall <= 1;
        hold--;
      end else if (mode == 1) begin
        out_stall <= ($urandom_range(0, 9) < 4);
      end else if (mode == 2) begin
        out_stall <= (cyc % 3 == 0);
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(got);
  end

  task automatic send_item(bus_item_t it);
    @(negedge clk);
    drv <= it;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    sent++;
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 0;
    end
  endtask

  task automatic write_reg(bdpt_pkg::cfg_idx_e idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic wait_drained();
    idle(1);
    while (sb.pending_q.size() != 0) @(posedge clk);
    idle(4);
  endtask

  task automatic load_settings(logic [7:0] a, logic [7:0] b, logic [15:0] t,
                               logic [7:0] i, logic [7:0] d, logic [7:0] bt,
                               logic [7:0] l);
    logic [7:0] up;
    up = 8'($urandom);
    write_reg(bdpt_pkg::CFG_MCU_FIRST, {up, a});
    write_reg(bdpt_pkg::CFG_MCU_SECOND, {~up, b});
    write_reg(bdpt_pkg::CFG_TIMEOUT, t);
    write_reg(bdpt_pkg::CFG_IGNITER, {up ^ 8'h5a, i});
    write_reg(bdpt_pkg::CFG_DETECTOR, {8'h00, d});
    write_reg(bdpt_pkg::CFG_BUTTON, {8'hff, bt});
    write_reg(bdpt_pkg::CFG_LIMIT, {up, l});
    settings_used++;
  endtask

  function automatic bus_item_t msg(logic dir, logic [7:0] ty, logic [6:0] z,
                                    logic [7:0] h, logic [5:0] l, logic [7:0] c);
    bus_item_t it;
    it.op = bdpt_pkg::OP_MSG; it.now = cur_now; it.dir = dir; it.dtype = ty;
    it.zone = z; it.hadr = h; it.ladr = l; it.cmd = c;
    it.rest = 56'({$urandom, $urandom});
    return it;
  endfunction

  function automatic bus_item_t tick_at(logic [31:0] t);
    bus_item_t it;
    it = msg(1'b0, 8'd0, 7'd0, 8'd0, 6'd0, 8'd0);
    it.op = bdpt_pkg::OP_TICK; it.now = t;
    return it;
  endfunction

  function automatic bus_item_t random_item();
    bus_item_t it;
    logic [7:0] vt;
    int k, sel;
    sel = $urandom_range(0, 99);
    cur_now += $urandom_range(0, 400);
    if (sel < 30) begin
      k = $urandom_range(0, 39);
      it = msg(1'b1, pool_type[k], pool_zone[k], pool_hadr[k], pool_ladr[k],
               8'($urandom_range(1, 255)));
    end else if (sel < 40) begin
      k = $urandom_range(0, 39);
      it = msg(1'($urandom_range(0, 1)), pool_type[k], pool_zone[k], pool_hadr[k],
               pool_ladr[k], 8'd0);
    end else if (sel < 80) begin
      k = $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0: vt = sb.ign;
        1: vt = sb.det;
        2: vt = sb.btn;
        default: vt = sb.lim;
      endcase
      it = msg(1'b1, vt, pool_zone[k], pool_hadr[k], 6'($urandom_range(0, 18)),
               8'($urandom_range(0, 3)));
    end else if (sel < 88) begin
      it = tick_at(cur_now);
    end else if (sel < 89) begin
      it = tick_at(cur_now);
      it.op = bdpt_pkg::OP_CLEAR;
    end else begin
      it.op = bdpt_pkg::op_e'($urandom_range(0, 3)); it.now = $urandom;
      it.dir = 1'($urandom);
      it.dtype = 8'($urandom); it.zone = 7'($urandom); it.hadr = 8'($urandom);
      it.ladr = 6'($urandom); it.cmd = 8'($urandom);
      it.rest = 56'({$urandom, $urandom});
    end
    return it;
  endfunction

  task automatic build_pool();
    for (int k = 0; k < 40; k++) begin
      pool_type[k] = $urandom_range(0, 1) ? sb.mcu_a : sb.mcu_b;
      pool_zone[k] = (k < 8) ? 7'(k * 17) : 7'($urandom_range(0, 3) * 41);
      pool_hadr[k] = (k < 8) ? 8'(255 - k) : 8'($urandom_range(0, 3) * 85);
      pool_ladr[k] = 6'($urandom);
    end
  endtask

  task automatic random_phase(int count);
    int n, burst;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst && n < count; j++) begin
        send_item(random_item());
        n++;
      end
      if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
    end
  endtask

  task automatic directed();
    bus_item_t it;
    cur_now = 32'd1000;
    send_item(msg(1'b1, 8'd13, 7'd5, 8'd10, 6'd1, 8'd1));
    send_item(msg(1'b1, 8'd13, 7'd5, 8'd10, 6'd1, 8'd2));
    send_item(msg(1'b1, 8'd14, 7'd5, 8'd10, 6'd2, 8'd1));
    it = msg(1'b1, 8'd13, 7'd5, 8'd10, 6'd1, 8'd0);
    it.rest[39:32] = 8'ha5;
    send_item(it);
    send_item(msg(1'b0, 8'd14, 7'd5, 8'd10, 6'd2, 8'd0));
    send_item(msg(1'b0, 8'd14, 7'd9, 8'd9, 6'd9, 8'd0));
    send_item(msg(1'b1, 8'd1, 7'd5, 8'd10, 6'd3, 8'd7));
    send_item(msg(1'b1, 8'd1, 7'd5, 8'd10, 6'd3, 8'd7));
    send_item(msg(1'b1, 8'd1, 7'd5, 8'd10, 6'd3, 8'd9));
    send_item(msg(1'b1, 8'd1, 7'd5, 8'd10, 6'd3, 8'd7));
    send_item(msg(1'b1, 8'd4, 7'd5, 8'd10, 6'd63, 8'd0));
    send_item(msg(1'b1, 8'd2, 7'd6, 8'd10, 6'd3, 8'd1));
    send_item(msg(1'b0, 8'd3, 7'd5, 8'd10, 6'd4, 8'd1));
    send_item(msg(1'b1, 8'd99, 7'd5, 8'd10, 6'd4, 8'd1));
    it = tick_at(32'd0);
    it.op = bdpt_pkg::OP_NONE;
    send_item(it);
    send_item(tick_at(32'd6000));
    send_item(tick_at(32'd6001));
    send_item(msg(1'b1, 8'd3, 7'd5, 8'd10, 6'd4, 8'd1));
    cur_now = 32'hffff_ff00;
    send_item(msg(1'b1, 8'd13, 7'd5, 8'd10, 6'd1, 8'd1));
    send_item(tick_at(32'h0000_1000));
    send_item(tick_at(32'h0000_1389));
    send_item(tick_at(32'd0));
    send_item(msg(1'b1, 8'd14, 7'h7f, 8'hff, 6'h3f, 8'hff));
    it = tick_at(32'd0);
    it.op = bdpt_pkg::OP_CLEAR;
    send_item(it);
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
    in_valid = 0;
    drv = '0;
    hold_cycles_req = 0;
    sent = 0;
    settings_used = 0;
    sb = new();
    repeat (11) @(negedge clk);
    rst_n = 1;

    load_settings(8'd13, 8'd14, 16'd5000, 8'd1, 8'd2, 8'd3, 8'd4);
    directed();
    build_pool();
    random_phase(200);
    wait_drained();

    // extremes; receiver holds off while the sender keeps pushing
    load_settings(8'h00, 8'hff, 16'd0, 8'hff, 8'h00, 8'h80, 8'h55);
    build_pool();
    hold_cycles_req = 400;
    for (int j = 0; j < 30; j++) send_item(random_item());
    random_phase(180);
    wait_drained();

    load_settings(8'd200, 8'd200, 16'hffff, 8'd7, 8'd8, 8'd9, 8'd200);
    cur_now = 32'hffff_0000;
    build_pool();
    random_phase(210);
    wait_drained();

    load_settings(8'($urandom), 8'($urandom), 16'($urandom_range(100, 3000)),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    build_pool();
    random_phase(220);

    idle(1);
    for (int g = 0; g < 200000 && sb.pending_q.size() != 0; g++) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));

    $display("ran %0d transfers under %0d register settings, %0d results checked",
             sent, settings_used, sb.checked);
    $display("controller table full %0d times, parent full %0d, %0d controllers aged",
             sb.full_seen, sb.parent_full_seen, sb.aged_seen);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bdpt_pkg.sv
hw/rtl/bdpt_fifo.sv
hw/rtl/bdpt_front.sv
hw/rtl/bdpt_back.sv
hw/rtl/bus_device_presence_table_unit.sv
verif/tb_bus_device_presence_table_unit.sv
